>>> rtl/core/frustum_box_classify_macros.svh
// Assertion macros for the frustum box classifier.
`ifndef FRUSTUM_BOX_CLASSIFY_MACROS_SVH
`define FRUSTUM_BOX_CLASSIFY_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition that must hold at every rising clock edge outside reset.
`define FBC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fbc check failed");
// Antecedent this cycle implies consequent in the next cycle.
`define FBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbc check failed");
`else
`define FBC_ASSERT(lbl, cond)
`define FBC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/fbc_pkg.sv
// Shared types and constants of the frustum box classifier.
`default_nettype none
package fbc_pkg;

  localparam int FBC_PLANE_COUNT = 6;   // planes tested by default
  localparam int FBC_REG_COUNT   = 6;   // plane registers present
  localparam int FBC_CFG_IDX_W   = 3;
  localparam int FBC_CFG_W       = 64;
  localparam int FBC_COORD_W     = 16;
  localparam int FBC_PROD_W      = 2 * FBC_COORD_W;
  // three products plus the scaled offset fit in 34 bits signed
  localparam int FBC_SUM_W       = FBC_PROD_W + 2;
  localparam int FBC_FRAC_W      = 8;
  localparam int FBC_IN_DATA_W   = 6 * FBC_COORD_W;
  localparam int FBC_OUT_DATA_W  = 8;
  localparam int FBC_VERDICT_W   = 2;

  localparam logic [FBC_VERDICT_W-1:0] VERDICT_OUTSIDE = 2'd0;
  localparam logic [FBC_VERDICT_W-1:0] VERDICT_INTER   = 2'd1;
  localparam logic [FBC_VERDICT_W-1:0] VERDICT_INSIDE  = 2'd2;

  typedef logic signed [FBC_COORD_W-1:0] coord_t;
  typedef logic signed [FBC_PROD_W-1:0]  prod_t;
  typedef logic signed [FBC_SUM_W-1:0]   sum_t;

  // box request travelling down the chain with its running flags
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    logic   test_inner;
    logic   outside;     // some plane has the near corner above zero
    logic   all_in;      // far corner below zero on every plane so far
  } item_t;

endpackage
`default_nettype wire

>>> rtl/core/fbc_cell.sv
// One plane cell: near/far corner products, then sums and flag update.
`default_nettype none
module fbc_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [fbc_pkg::FBC_CFG_W-1:0] plane,
  input  wire                          up_valid,
  output logic                         up_ready,
  input  fbc_pkg::item_t               up_item,
  output logic                         dn_valid,
  input  wire                          dn_ready,
  output fbc_pkg::item_t               dn_item
);
  import fbc_pkg::*;

  coord_t nx, ny, nz, d;
  coord_t near_cx, near_cy, near_cz, far_cx, far_cy, far_cz;
  prod_t  np_x_nxt, np_y_nxt, np_z_nxt, fp_x_nxt, fp_y_nxt, fp_z_nxt;
  prod_t  np_x_r, np_y_r, np_z_r, fp_x_r, fp_y_r, fp_z_r;
  item_t  s1_item_r, s2_item_r, s2_item_nxt;
  logic   s1_valid_r, s2_valid_r;
  logic   s1_ready, s2_ready;
  sum_t   d_term, near_sum, far_sum;

  assign nx = coord_t'(plane[15:0]);
  assign ny = coord_t'(plane[31:16]);
  assign nz = coord_t'(plane[47:32]);
  assign d  = coord_t'(plane[63:48]);

  // corner choice per axis: positive normal takes the minimum for the near corner
  always_comb begin
    near_cx = (nx > 0) ? up_item.min_x : up_item.max_x;
    near_cy = (ny > 0) ? up_item.min_y : up_item.max_y;
    near_cz = (nz > 0) ? up_item.min_z : up_item.max_z;
    far_cx  = (nx > 0) ? up_item.max_x : up_item.min_x;
    far_cy  = (ny > 0) ? up_item.max_y : up_item.min_y;
    far_cz  = (nz > 0) ? up_item.max_z : up_item.min_z;
    np_x_nxt = prod_t'(nx) * prod_t'(near_cx);
    np_y_nxt = prod_t'(ny) * prod_t'(near_cy);
    np_z_nxt = prod_t'(nz) * prod_t'(near_cz);
    fp_x_nxt = prod_t'(nx) * prod_t'(far_cx);
    fp_y_nxt = prod_t'(ny) * prod_t'(far_cy);
    fp_z_nxt = prod_t'(nz) * prod_t'(far_cz);
  end

  // handshake between the two stages
  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  // offset scaled to the product format, then exact sums
  always_comb begin
    d_term   = sum_t'($signed({{(FBC_SUM_W-FBC_COORD_W-FBC_FRAC_W){d[FBC_COORD_W-1]}},
                               d, {FBC_FRAC_W{1'b0}}}));
    near_sum = d_term + sum_t'(np_x_r) + sum_t'(np_y_r) + sum_t'(np_z_r);
    far_sum  = d_term + sum_t'(fp_x_r) + sum_t'(fp_y_r) + sum_t'(fp_z_r);
    s2_item_nxt         = s1_item_r;
    s2_item_nxt.outside = s1_item_r.outside || (near_sum > 0);
    s2_item_nxt.all_in  = s1_item_r.all_in && (far_sum < 0);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= up_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_item_r <= up_item;
      np_x_r    <= np_x_nxt;
      np_y_r    <= np_y_nxt;
      np_z_r    <= np_z_nxt;
      fp_x_r    <= fp_x_nxt;
      fp_y_r    <= fp_y_nxt;
      fp_z_r    <= fp_z_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_item  = s2_item_r;

endmodule
`default_nettype wire

>>> rtl/core/frustum_box_classify.sv
// Top level of the frustum box classifier: plane registers and the cell chain.
`default_nettype none
`include "frustum_box_classify_macros.svh"
// Classifies one axis-aligned box per cycle, unless out_tready stalls the chain,
// against PLANE_COUNT frustum planes with the near/far corner test. Each plane
// is a cell of two register stages (six 16x16 products, then the exact sums and
// sign checks), and a new box can be taken in every cycle; backpressure on
// out_tready ripples back stage by stage, so empty stages keep accepting. The
// user must write planes through the cfg_ port only while no box is in flight;
// the block does not enforce this. Any planes past index five read as zero.
// Verdict: outside, intersecting, or fully inside (only with in_tuser set).
module frustum_box_classify #(
  parameter int PLANE_COUNT = fbc_pkg::FBC_PLANE_COUNT
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire [fbc_pkg::FBC_CFG_IDX_W-1:0]  cfg_index,
  input  wire [fbc_pkg::FBC_CFG_W-1:0]      cfg_data,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  wire [fbc_pkg::FBC_IN_DATA_W-1:0]  in_tdata,
  // test_inner
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // verdict, zero fill
  output logic [fbc_pkg::FBC_OUT_DATA_W-1:0] out_tdata
);
  import fbc_pkg::*;

  logic [FBC_CFG_W-1:0] plane_r [FBC_REG_COUNT];
  logic [FBC_CFG_W-1:0] plane_sel [PLANE_COUNT];
  item_t                chain_item [PLANE_COUNT+1];
  logic                 chain_valid [PLANE_COUNT+1];
  logic                 chain_ready [PLANE_COUNT+1];
  item_t                last;
  logic [FBC_VERDICT_W-1:0] verdict;

  // plane registers; writes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FBC_REG_COUNT; i++) plane_r[i] <= '0;
    end else if (cfg_we && (cfg_index < FBC_CFG_IDX_W'(FBC_REG_COUNT))) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  // unpack the request into the head of the chain
  always_comb begin
    chain_item[0].min_x      = coord_t'(in_tdata[15:0]);
    chain_item[0].min_y      = coord_t'(in_tdata[31:16]);
    chain_item[0].min_z      = coord_t'(in_tdata[47:32]);
    chain_item[0].max_x      = coord_t'(in_tdata[63:48]);
    chain_item[0].max_y      = coord_t'(in_tdata[79:64]);
    chain_item[0].max_z      = coord_t'(in_tdata[95:80]);
    chain_item[0].test_inner = in_tuser;
    chain_item[0].outside    = 1'b0;
    chain_item[0].all_in     = 1'b1;
  end
  assign chain_valid[0] = in_tvalid;
  assign in_tready      = chain_ready[0];

  // one cell per plane
  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    if (g < FBC_REG_COUNT) begin : g_reg
      assign plane_sel[g] = plane_r[g];
    end else begin : g_zero
      assign plane_sel[g] = '0;
    end
    fbc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (plane_sel[g]),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_item  (chain_item[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_item  (chain_item[g+1])
    );
  end

  // verdict from the flags of the last cell
  assign last = chain_item[PLANE_COUNT];
  always_comb begin
    if (last.outside) begin
      verdict = VERDICT_OUTSIDE;
    end else if (last.test_inner && last.all_in) begin
      verdict = VERDICT_INSIDE;
    end else begin
      verdict = VERDICT_INTER;
    end
  end

  assign chain_ready[PLANE_COUNT] = out_tready;
  assign out_tvalid = chain_valid[PLANE_COUNT];
  assign out_tdata  = {{(FBC_OUT_DATA_W-FBC_VERDICT_W){1'b0}}, verdict};

  // checks
  `FBC_ASSERT(a_verdict_legal, !out_tvalid || (out_tdata[1:0] == VERDICT_OUTSIDE) || (out_tdata[1:0] == VERDICT_INTER) || (out_tdata[1:0] == VERDICT_INSIDE))
  `FBC_ASSERT(a_no_inside_without_test, !(out_tvalid && !last.test_inner) || (verdict != VERDICT_INSIDE))
  `FBC_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Testbench for frustum_box_classify: random and directed boxes checked against a verdict predictor.
`default_nettype none
module testbench;
  import fbc_pkg::*;

  localparam int LATENCY_CYCLES   = 2 * FBC_PLANE_COUNT;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int BOXES_PER_PHASE  = 300;
  localparam int SLOT_COUNT       = 1 << FBC_CFG_IDX_W;
  localparam int MAX_PRINTED      = 50;
  localparam longint TIMEOUT      = 64'd10_000_000;

  // one box request: corners indexed x, y, z from bit 0 up
  typedef struct packed {
    logic               inner;
    coord_t [2:0]       hi;
    coord_t [2:0]       lo;
  } box_req_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [FBC_CFG_IDX_W-1:0] cfg_index = '0;
  logic [FBC_CFG_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  logic [FBC_IN_DATA_W-1:0] in_tdata = '0;
  // test_inner
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // verdict, zero fill
  logic [FBC_OUT_DATA_W-1:0] out_tdata;

  box_req_t box_requests[$];
  logic [FBC_VERDICT_W-1:0] expected_verdicts[$];
  logic [FBC_CFG_W-1:0] plane_mirror [SLOT_COUNT];

  bit box_taken = 1'b0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit long_hold_request = 1'b0;
  int send_gap_left = 0;
  int ready_hold_left = 0;
  int mismatch_count = 0;

  frustum_box_classify uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // near/far corner verdict from the mirrored planes
  function automatic logic [FBC_VERDICT_W-1:0] classify_box(box_req_t b);
    longint near_dist, far_dist, nv, lo_v, hi_v;
    logic [FBC_CFG_W-1:0] plane;
    coord_t c;
    int inside_planes;
    inside_planes = 0;
    for (int i = 0; i < FBC_PLANE_COUNT; i++) begin
      plane = plane_mirror[i];
      c = plane[63:48];
      near_dist = longint'(c) * 256;
      far_dist = near_dist;
      for (int a = 0; a < 3; a++) begin
        c = plane[16*a +: 16];
        nv = longint'(c);
        c = b.lo[a];
        lo_v = longint'(c);
        c = b.hi[a];
        hi_v = longint'(c);
        // zero component goes with the negative side
        if (nv > 0) begin
          near_dist += nv * lo_v;
          far_dist += nv * hi_v;
        end else begin
          near_dist += nv * hi_v;
          far_dist += nv * lo_v;
        end
      end
      if (near_dist > 0) return VERDICT_OUTSIDE;
      if (b.inner && far_dist < 0) inside_planes++;
    end
    return (b.inner && inside_planes == FBC_PLANE_COUNT) ? VERDICT_INSIDE : VERDICT_INTER;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v > 32767) return coord_t'(16'h7FFF);
    if (v < -32768) return coord_t'(16'h8000);
    return coord_t'(v);
  endfunction

  function automatic box_req_t make_box(int lx, int ly, int lz, int hx, int hy, int hz,
                                        bit inner);
    box_req_t b;
    b.lo = {16'(lz), 16'(ly), 16'(lx)};
    b.hi = {16'(hz), 16'(hy), 16'(hx)};
    b.inner = inner;
    return b;
  endfunction

  // mostly boxes around the frustum, some raw noise (min above max included)
  function automatic box_req_t rand_box(int reach);
    box_req_t b;
    int centre, half;
    bit formed;
    formed = ($urandom_range(0, 3) != 0);
    b.inner = ($urandom_range(0, 3) != 0);
    for (int a = 0; a < 3; a++) begin
      if (formed) begin
        centre = $urandom_range(0, 4 * reach) - 2 * reach;
        half = ($urandom_range(0, 9) < 7) ? $urandom_range(0, reach / 4)
                                          : $urandom_range(0, 2 * reach);
        b.lo[a] = clamp_coord(centre - half);
        b.hi[a] = clamp_coord(centre + half);
      end else begin
        b.lo[a] = coord_t'($urandom);
        b.hi[a] = coord_t'($urandom);
      end
    end
    return b;
  endfunction

  // mostly short idles, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
  endtask

  // plane register write; the block is idle whenever this runs
  task automatic write_plane(input int idx, input logic [FBC_CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[FBC_CFG_IDX_W-1:0];
    cfg_data <= value;
    if (idx < FBC_REG_COUNT) plane_mirror[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // axis-aligned cube of half size reach, normals tilted by up to tilt
  task automatic load_frustum(input int reach, input int tilt);
    int comp [3];
    int d;
    for (int i = 0; i < FBC_REG_COUNT; i++) begin
      for (int a = 0; a < 3; a++) comp[a] = $urandom_range(0, 2 * tilt) - tilt;
      comp[i / 2] += (i % 2) ? -256 : 256;
      d = -reach;
      write_plane(i, {16'(d), 16'(comp[2]), 16'(comp[1]), 16'(comp[0])});
    end
  endtask

  // every request accepted and every verdict returned
  task automatic wait_drained();
    do @(negedge clk);
    while (box_requests.size() != 0 || in_tvalid || expected_verdicts.size() != 0);
  endtask

  task automatic run_boxes(input int reach, input int count, input bit snd_idle,
                           input bit rcv_idle);
    @(posedge clk);
    sender_idles = snd_idle;
    receiver_idles = rcv_idle;
    repeat (count) box_requests.push_back(rand_box(reach));
  endtask

  // driver: holds a request until taken, then idles at random when sender_idles is set
  always @(negedge clk) begin
    logic offer;
    if (!rst_n) begin
      offer = 1'b0;
    end else if (in_tvalid && !box_taken) begin
      offer = 1'b1;
    end else begin
      if (box_taken) begin
        box_taken = 1'b0;
        box_requests.delete(0);
        if (sender_idles) send_gap_left = pick_gap();
      end
      if (send_gap_left > 0) begin
        send_gap_left--;
        offer = 1'b0;
      end else begin
        offer = (box_requests.size() != 0);
      end
    end
    in_tvalid <= offer;
    if (offer) begin
      in_tdata <= {box_requests[0].hi, box_requests[0].lo};
      in_tuser <= box_requests[0].inner;
    end
  end

  // receiver: random stalls when receiver_idles is set, plus one long hold-off on request
  always @(negedge clk) begin
    logic ready_next;
    if (!rst_n) begin
      ready_next = 1'b0;
    end else begin
      if (long_hold_request) begin
        ready_hold_left = LONG_HOLD_CYCLES;
        long_hold_request = 1'b0;
      end else if (ready_hold_left == 0 && receiver_idles && $urandom_range(0, 3) == 0) begin
        ready_hold_left = pick_gap();
      end
      if (ready_hold_left > 0) begin
        ready_hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
    end
    out_tready <= ready_next;
  end

  // monitor: check results first, then log the box taken on this edge
  always @(posedge clk) begin
    box_req_t seen;
    logic [FBC_OUT_DATA_W-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no box in flight", out_tdata));
        end else begin
          want = {{(FBC_OUT_DATA_W-FBC_VERDICT_W){1'b0}}, expected_verdicts.pop_front()};
          if (out_tdata !== want)
            report_mismatch($sformatf("out_tdata %h, expected %h", out_tdata, want));
        end
      end
      if (in_tvalid && in_tready) begin
        seen.lo = in_tdata[3*FBC_COORD_W-1:0];
        seen.hi = in_tdata[6*FBC_COORD_W-1:3*FBC_COORD_W];
        seen.inner = in_tuser;
        expected_verdicts.push_back(classify_box(seen));
        box_taken = 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    int reach, guard;
    logic [15:0] field [4];
    for (int i = 0; i < SLOT_COUNT; i++) plane_mirror[i] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // planes at reset value: all distances zero
    @(posedge clk);
    box_requests.push_back(make_box(0, 0, 0, 0, 0, 0, 1'b0));
    box_requests.push_back(make_box(0, 0, 0, 0, 0, 0, 1'b1));
    box_requests.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b1));
    box_requests.push_back(make_box(32767, 32767, 32767, -32768, -32768, -32768, 1'b1));
    wait_drained();
    // indexes past the register file are dropped
    for (int i = FBC_REG_COUNT; i < SLOT_COUNT; i++) write_plane(i, '1);
    box_requests.push_back(make_box(-256, -256, -256, 256, 256, 256, 1'b1));
    wait_drained();

    // cube of half size 16.0, zero normal components
    load_frustum(16'h1000, 0);
    box_requests.push_back(make_box(-256, -256, -256, 256, 256, 256, 1'b1));
    box_requests.push_back(make_box(-256, -256, -256, 256, 256, 256, 1'b0));
    box_requests.push_back(make_box(16'h1100, 0, 0, 16'h1200, 256, 256, 1'b1));
    // near corner exactly on the plane
    box_requests.push_back(make_box(16'h1000, 0, 0, 16'h1100, 256, 256, 1'b1));
    // far corner exactly on the plane
    box_requests.push_back(make_box(-256, -256, -256, 16'h1000, 256, 256, 1'b1));
    box_requests.push_back(make_box(-8192, -256, -256, 0, 256, 256, 1'b1));
    box_requests.push_back(make_box(256, 256, 256, -256, -256, -256, 1'b1));
    box_requests.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b1));
    wait_drained();

    // extreme plane terms
    for (int i = 0; i < FBC_REG_COUNT; i++) write_plane(i, 64'h8000_8000_8000_8000);
    box_requests.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b1));
    box_requests.push_back(make_box(32767, 32767, 32767, -32768, -32768, -32768, 1'b1));
    box_requests.push_back(make_box(0, 0, 0, 0, 0, 0, 1'b1));
    wait_drained();
    for (int i = 0; i < FBC_REG_COUNT; i++) write_plane(i, 64'h7FFF_7FFF_7FFF_7FFF);
    box_requests.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b1));
    box_requests.push_back(make_box(32767, 32767, 32767, -32768, -32768, -32768, 1'b0));
    wait_drained();

    // random: plain cube, idles on both sides
    reach = $urandom_range(16'h0800, 16'h4000);
    load_frustum(reach, 0);
    run_boxes(reach, BOXES_PER_PHASE, 1'b1, 1'b1);
    wait_drained();

    // tilted cube; long receiver hold while the sender keeps offering
    reach = $urandom_range(16'h0800, 16'h4000);
    load_frustum(reach, 48);
    run_boxes(reach, BOXES_PER_PHASE, 1'b0, 1'b1);
    long_hold_request = 1'b1;
    wait_drained();

    // fully random planes
    for (int i = 0; i < FBC_REG_COUNT; i++) write_plane(i, {$urandom, $urandom});
    run_boxes(16'h4000, BOXES_PER_PHASE, 1'b1, 1'b1);
    wait_drained();

    // slight tilt, many zero components, no idling at all
    reach = $urandom_range(16'h0100, 16'h2000);
    load_frustum(reach, 2);
    run_boxes(reach, BOXES_PER_PHASE, 1'b0, 1'b0);
    wait_drained();

    // plane fields drawn from the extremes
    for (int i = 0; i < FBC_REG_COUNT; i++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 4))
          0: field[k] = 16'h8000;
          1: field[k] = 16'h7FFF;
          2: field[k] = 16'h0000;
          3: field[k] = 16'hFFFF;
          default: field[k] = 16'h0001;
        endcase
      end
      write_plane(i, {field[3], field[2], field[1], field[0]});
    end
    run_boxes(16'h7FFF, BOXES_PER_PHASE, 1'b1, 1'b1);
    wait_drained();

    // widest cube, boxes reaching the coordinate limits
    load_frustum(16'h7FFF, 16);
    run_boxes(16'h7FFF, BOXES_PER_PHASE, 1'b1, 1'b1);

    // all requests in, then wait for the pipeline to empty
    do @(negedge clk);
    while (box_requests.size() != 0 || in_tvalid);
    guard = 0;
    while (expected_verdicts.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (2 * LATENCY_CYCLES + 4) @(negedge clk);
    if (expected_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never returned", expected_verdicts.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #TIMEOUT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
